@@ rtl/core/bdq_pkg.sv @@
// Package for the bounded deque with search: sizes, operation and status codes,
// the item structs on both channels and the ring index helper.
// No dependencies.
package bdq_pkg;

	// Ring size and the widths that follow from it.
	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int OPC_W   = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Operation codes as they arrive on the input channel.
	typedef enum logic [OPC_W-1:0] {
		OPC_APPEND    = 3'd0,
		OPC_POP_FRONT = 3'd1,
		OPC_POP_BACK  = 3'd2,
		OPC_SEARCH    = 3'd3,
		OPC_CLEAR     = 3'd4
	} opcode_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Classified command kinds passed from the front to the back.
	typedef enum logic [2:0] {
		CMD_APPEND,
		CMD_POP_FRONT,
		CMD_POP_BACK,
		CMD_SEARCH,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	// Back-end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_SEARCH
	} back_state_t;

	typedef struct packed {
		logic [OPC_W-1:0]          opcode;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               found;
		logic [COUNT_W-1:0] count;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	// Position in the ring a given offset behind a base position. Both
	// operands are below DEPTH, so one compare and subtract wraps the sum.
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] offset);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= (IDX_W+1)'(DEPTH)) begin
			sum = sum - (IDX_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

@@ rtl/core/bdq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/bdq_front.sv @@
// Front end of the deque: accepts items, classifies the opcode and holds the
// resulting commands in a two-entry queue for the back end. Uses bdq_pkg.
module bdq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bdq_pkg::in_item_t in_item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output bdq_pkg::cmd_t     cmd
);

	bdq_pkg::cmd_t cmd_new;
	bdq_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    used_q;
	logic          push;
	logic          pop;

	// Map the raw opcode onto a command kind; unused codes become no-ops.
	always_comb begin
		cmd_new.value = in_item.value;
		case (in_item.opcode)
			bdq_pkg::OPC_APPEND:    cmd_new.kind = bdq_pkg::CMD_APPEND;
			bdq_pkg::OPC_POP_FRONT: cmd_new.kind = bdq_pkg::CMD_POP_FRONT;
			bdq_pkg::OPC_POP_BACK:  cmd_new.kind = bdq_pkg::CMD_POP_BACK;
			bdq_pkg::OPC_SEARCH:    cmd_new.kind = bdq_pkg::CMD_SEARCH;
			bdq_pkg::OPC_CLEAR:     cmd_new.kind = bdq_pkg::CMD_CLEAR;
			default:                cmd_new.kind = bdq_pkg::CMD_NOP;
		endcase
	end

	assign in_ready  = (used_q != 2'd2);
	assign cmd_valid = (used_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				used_q <= used_q + 2'd1;
			end else if (pop && !push) begin
				used_q <= used_q - 2'd1;
			end
		end
	end

	// Queue payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

@@ rtl/core/bdq_back.sv @@
// Back end of the deque: executes commands against the ring, walks the stored
// entries for a search and holds the result register. Uses bdq_pkg, bdq_ram.
module bdq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  bdq_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output bdq_pkg::out_item_t out_item
);

	bdq_pkg::back_state_t             state_q, state_d;
	logic [bdq_pkg::CNT_W-1:0]        fill_q, fill_d;
	logic [bdq_pkg::IDX_W-1:0]        front_q, front_d;
	logic [bdq_pkg::IDX_W-1:0]        off_q, off_d;
	logic [bdq_pkg::VALUE_W-1:0]      key_q, key_d;
	logic                             out_valid_q;
	bdq_pkg::out_item_t               out_item_q;
	bdq_pkg::out_item_t               res;
	logic                             load;
	logic                             out_free;
	logic                             take;
	logic                             full;
	logic                             empty;
	logic                             hit;
	logic                             last;
	logic                             ram_wr_en;
	logic [bdq_pkg::IDX_W-1:0]        ram_wr_addr;
	logic                             ram_rd_en;
	logic [bdq_pkg::IDX_W-1:0]        ram_rd_addr;
	logic [bdq_pkg::VALUE_W-1:0]      ram_rd_data;

	assign out_free = !out_valid_q || out_ready;
	assign take     = (state_q == bdq_pkg::BK_IDLE) && cmd_valid && out_free;
	assign full     = (fill_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
	assign empty    = (fill_q == '0);
	assign hit      = (ram_rd_data == key_q);
	assign last     = ((bdq_pkg::CNT_W'(off_q) + bdq_pkg::CNT_W'(1)) == fill_q);

	// Next state, ring pointers and the result to be registered.
	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		front_d     = front_q;
		off_d       = off_q;
		key_d       = key_q;
		load        = 1'b0;
		res.status  = bdq_pkg::STAT_DONE;
		res.found   = 1'b0;
		case (state_q)
			bdq_pkg::BK_IDLE: begin
				if (take) begin
					load = 1'b1;
					case (cmd.kind)
						bdq_pkg::CMD_APPEND: begin
							if (full) begin
								res.status = bdq_pkg::STAT_FULL;
							end else begin
								fill_d = fill_q + bdq_pkg::CNT_W'(1);
							end
						end
						bdq_pkg::CMD_POP_FRONT: begin
							if (empty) begin
								res.status = bdq_pkg::STAT_EMPTY;
							end else begin
								front_d = bdq_pkg::ring_add(front_q, bdq_pkg::IDX_W'(1));
								fill_d  = fill_q - bdq_pkg::CNT_W'(1);
							end
						end
						bdq_pkg::CMD_POP_BACK: begin
							if (empty) begin
								res.status = bdq_pkg::STAT_EMPTY;
							end else begin
								fill_d = fill_q - bdq_pkg::CNT_W'(1);
							end
						end
						bdq_pkg::CMD_SEARCH: begin
							// A non-empty store starts the walk at the front entry.
							if (!empty) begin
								load    = 1'b0;
								state_d = bdq_pkg::BK_SEARCH;
								off_d   = '0;
								key_d   = cmd.value;
							end
						end
						bdq_pkg::CMD_CLEAR: begin
							fill_d  = '0;
							front_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			bdq_pkg::BK_SEARCH: begin
				// The entry at off_q is on the read port; stop on a match or at the back.
				if (hit || last) begin
					load      = 1'b1;
					res.found = hit;
					state_d   = bdq_pkg::BK_IDLE;
				end else begin
					off_d = off_q + bdq_pkg::IDX_W'(1);
				end
			end
			default: begin
				state_d = bdq_pkg::BK_IDLE;
			end
		endcase
		res.count = bdq_pkg::COUNT_W'(fill_d);
	end

	// Memory controls and the command handshake.
	always_comb begin
		cmd_ready   = take;
		ram_wr_en   = take && (cmd.kind == bdq_pkg::CMD_APPEND) && !full;
		ram_wr_addr = bdq_pkg::ring_add(front_q, fill_q[bdq_pkg::IDX_W-1:0]);
		ram_rd_en   = 1'b0;
		ram_rd_addr = front_q;
		case (state_q)
			bdq_pkg::BK_IDLE: begin
				ram_rd_en   = take && (cmd.kind == bdq_pkg::CMD_SEARCH);
				ram_rd_addr = front_q;
			end
			bdq_pkg::BK_SEARCH: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = bdq_pkg::ring_add(front_q, off_q + bdq_pkg::IDX_W'(1));
			end
			default: begin
			end
		endcase
	end

	bdq_ram #(
		.WIDTH(bdq_pkg::VALUE_W),
		.DEPTH(bdq_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(cmd.value),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Control state and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::BK_IDLE;
			fill_q      <= '0;
			front_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			front_q <= front_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search bookkeeping and result payload.
	always_ff @(posedge clk) begin
		off_q <= off_d;
		key_q <= key_d;
		if (load) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ rtl/core/bounded_deque_with_search.sv @@
// Top level of the bounded deque with linear search.
// Uses bdq_pkg, bdq_front and bdq_back.
//
// The block keeps an ordered store of up to DEPTH signed 32-bit values in a ring.
// Input channel (in_valid, in_ready, in_item): each item carries an opcode and a
// value; append, remove front, remove back, search and clear are supported.
// Output channel (out_valid, out_ready, out_item): exactly one result item per
// input item, in order, giving status, found flag and the count after the item.
// Accepted items enter a two-entry command queue, so the input side keeps
// taking items while the back end is busy or a result waits to be collected.
// Every accepted item passes a command queue slot and then the result register
// before its result is valid. A search reads one stored entry a cycle through
// the single read port of the entry RAM, comparing entries from the front until
// a match or the back is reached.
// Throughput is one item every cycle for queue operations while the receiver
// keeps up; the back end takes no new item while a search walks the store.
// Reset clears the count and front position; the entry RAM is not cleared,
// since only entries written by an earlier append are ever compared.
// If the receiver stalls, the result holds in the output register and the back
// end waits; the input keeps accepting until the command queue is full.
module bounded_deque_with_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bdq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output bdq_pkg::out_item_t out_item
);

	logic          cmd_valid;
	logic          cmd_ready;
	bdq_pkg::cmd_t cmd;

	bdq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	bdq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

@@ sim/bounded_deque_with_search_tb.sv @@
// Self-checking testbench for the bounded deque with linear search.
// Depends on bdq_pkg and the bounded_deque_with_search top level, which uses bdq_front, bdq_back and bdq_ram.
// A shadow ring predicts every result. The run is directed items, one back-pressure run, then random traffic.
module bounded_deque_with_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF    = 2;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_CAP   = 50;
	localparam int POOL_SIZE   = 8;

	// Opcodes past clear have no operation behind them.
	localparam logic [bdq_pkg::OPC_W-1:0] OPC_SPARE_LO = 3'(bdq_pkg::OPC_CLEAR) + 3'd1;
	localparam logic [bdq_pkg::OPC_W-1:0] OPC_SPARE_HI = '1;

	// Operation mix of one random segment.
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} op_mix_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	bdq_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	bdq_pkg::out_item_t out_item;

	// Shadow copy of the deque state.
	logic signed [bdq_pkg::VALUE_W-1:0] shadow_ring [bdq_pkg::DEPTH];
	int unsigned                        shadow_front = 0;
	int unsigned                        shadow_fill  = 0;

	bdq_pkg::out_item_t                 owed_results [$];
	bdq_pkg::out_item_t                 owed_head;
	logic signed [bdq_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
	int                                 error_count  = 0;
	int                                 result_index = 0;
	int                                 cycle_count  = 0;
	bit                                 tx_idle_en   = 1'b0;
	bit                                 rx_idle_en   = 1'b0;
	int                                 rx_hold_req  = 0;
	bit                                 rx_holding   = 1'b0;

	bounded_deque_with_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Prints one mismatch line and counts it; printing stops after a cap.
	task automatic flag_error(input string msg);
		if (error_count < PRINT_CAP) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	// Applies one item to the shadow deque and returns the result it should give.
	function automatic bdq_pkg::out_item_t shadow_deque_op(input bdq_pkg::in_item_t cmd);
		bdq_pkg::out_item_t res;
		int unsigned        k;
		logic               hit;
		res.status = bdq_pkg::STAT_DONE;
		hit        = 1'b0;
		case (cmd.opcode)
			bdq_pkg::OPC_APPEND: begin
				if (shadow_fill >= bdq_pkg::DEPTH) begin
					res.status = bdq_pkg::STAT_FULL;
				end else begin
					shadow_ring[(shadow_front + shadow_fill) % bdq_pkg::DEPTH] = cmd.value;
					shadow_fill++;
				end
			end
			bdq_pkg::OPC_POP_FRONT: begin
				if (shadow_fill == 0) begin
					res.status = bdq_pkg::STAT_EMPTY;
				end else begin
					shadow_front = (shadow_front + 1) % bdq_pkg::DEPTH;
					shadow_fill--;
				end
			end
			bdq_pkg::OPC_POP_BACK: begin
				if (shadow_fill == 0) begin
					res.status = bdq_pkg::STAT_EMPTY;
				end else begin
					shadow_fill--;
				end
			end
			bdq_pkg::OPC_SEARCH: begin
				// Only entries inside the stored range are compared.
				for (k = 0; k < shadow_fill; k++) begin
					if (!hit && shadow_ring[(shadow_front + k) % bdq_pkg::DEPTH] == cmd.value)
					begin
						hit = 1'b1;
					end
				end
			end
			bdq_pkg::OPC_CLEAR: begin
				shadow_fill  = 0;
				shadow_front = 0;
			end
			default: begin
			end
		endcase
		res.found = hit;
		res.count = bdq_pkg::COUNT_W'(shadow_fill);
		return res;
	endfunction

	// Predicts each accepted item and checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				flag_error($sformatf("result %0d arrived with nothing outstanding", result_index));
			end else begin
				owed_head = owed_results.pop_front();
				if (out_item.status !== owed_head.status) begin
					flag_error($sformatf("result %0d status want %0d got %0d", result_index,
						owed_head.status, out_item.status));
				end
				if (out_item.found !== owed_head.found) begin
					flag_error($sformatf("result %0d found want %0d got %0d", result_index,
						owed_head.found, out_item.found));
				end
				if (out_item.count !== owed_head.count) begin
					flag_error($sformatf("result %0d count want %0d got %0d", result_index,
						owed_head.count, out_item.count));
				end
			end
			result_index++;
		end
		if (in_valid && in_ready) begin
			owed_results.push_back(shadow_deque_op(in_item));
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Idle length: mostly short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			return $urandom_range(1, 3);
		end else if (r < 9) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Result receiver: ready with random idle stretches, or a long hold-off on request.
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			if (rx_hold_req > 0) begin
				n           = rx_hold_req;
				rx_hold_req = 0;
				out_ready  <= 1'b0;
				rx_holding  = 1'b1;
				repeat (n) @(negedge clk);
				rx_holding  = 1'b0;
			end else if (!rx_idle_en || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				@(negedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(negedge clk);
			end
		end
	end

	function automatic bdq_pkg::in_item_t mk_cmd(input logic [bdq_pkg::OPC_W-1:0] op,
		input logic signed [bdq_pkg::VALUE_W-1:0] val);
		bdq_pkg::in_item_t it;
		it.opcode = op;
		it.value  = val;
		return it;
	endfunction

	// Offers one item, holds it until accepted, then idles at random if enabled.
	// Valid stays high into the next item when no idle follows.
	task automatic push_command(input bdq_pkg::in_item_t it);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drops valid and waits until every outstanding result has been checked.
	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
	endtask

	// Value to append or search for: mostly from a small pool so that searches hit.
	function automatic logic signed [bdq_pkg::VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (r < 8) begin
			return $urandom;
		end else if (r == 8) begin
			case ($urandom_range(0, 3))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7fff_ffff;
				2:       return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return $urandom_range(0, 15);
	endfunction

	// One random item under the given operation mix.
	function automatic bdq_pkg::in_item_t pick_command(input op_mix_t mix);
		int                        r;
		int                        add_w;
		int                        pop_w;
		logic [bdq_pkg::OPC_W-1:0] op;
		add_w = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 15 : 30;
		pop_w = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 50 : 30;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			op = bdq_pkg::OPC_CLEAR;
		end else if (r < 5) begin
			op = bdq_pkg::OPC_W'($urandom_range(OPC_SPARE_HI, OPC_SPARE_LO));
		end else begin
			r = $urandom_range(0, 94);
			if (r < add_w) begin
				op = bdq_pkg::OPC_APPEND;
			end else if (r < add_w + pop_w) begin
				op = $urandom_range(0, 1) ? bdq_pkg::OPC_POP_FRONT : bdq_pkg::OPC_POP_BACK;
			end else begin
				op = bdq_pkg::OPC_SEARCH;
			end
		end
		// Refresh a pool slot now and then so hits keep moving.
		if ($urandom_range(0, 19) == 0) begin
			value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
		end
		return mk_cmd(op, pick_value());
	endfunction

	// Empty removals, spare opcodes, a full store with field extremes, and searches.
	task automatic test_directed();
		int                                 i;
		logic signed [bdq_pkg::VALUE_W-1:0] last_val;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		push_command(mk_cmd(bdq_pkg::OPC_POP_FRONT, 32'sd0));
		push_command(mk_cmd(bdq_pkg::OPC_POP_BACK, -32'sd1));
		push_command(mk_cmd(bdq_pkg::OPC_SEARCH, 32'sd0));
		push_command(mk_cmd(OPC_SPARE_LO, 32'sh7fff_ffff));
		push_command(mk_cmd(OPC_SPARE_HI, 32'sh8000_0000));
		push_command(mk_cmd(bdq_pkg::OPC_APPEND, 32'sh8000_0000));
		push_command(mk_cmd(bdq_pkg::OPC_APPEND, 32'sh7fff_ffff));
		push_command(mk_cmd(bdq_pkg::OPC_APPEND, -32'sd1));
		push_command(mk_cmd(bdq_pkg::OPC_APPEND, 32'sd0));
		for (i = 4; i < bdq_pkg::DEPTH; i++) begin
			last_val = (i % 2 == 0) ? (32'sh5555_5555 ^ i) : (32'shaaaa_aaaa + i);
			push_command(mk_cmd(bdq_pkg::OPC_APPEND, last_val));
		end
		// The store is full: this append is dropped and must not be found.
		push_command(mk_cmd(bdq_pkg::OPC_APPEND, 32'sd1));
		push_command(mk_cmd(bdq_pkg::OPC_SEARCH, 32'sh8000_0000));
		push_command(mk_cmd(bdq_pkg::OPC_SEARCH, last_val));
		push_command(mk_cmd(bdq_pkg::OPC_SEARCH, 32'sd1));
		push_command(mk_cmd(bdq_pkg::OPC_POP_FRONT, 32'sd0));
		push_command(mk_cmd(bdq_pkg::OPC_SEARCH, 32'sh8000_0000));
		push_command(mk_cmd(bdq_pkg::OPC_POP_BACK, 32'sd0));
		push_command(mk_cmd(bdq_pkg::OPC_CLEAR, 32'sd0));
		push_command(mk_cmd(bdq_pkg::OPC_POP_BACK, 32'sd0));
		wait_all_results();
	endtask

	// The receiver holds off while items keep coming, so the input must stall.
	task automatic test_back_pressure();
		int i;
		// The value pool must hold known values before any item draws from it.
		for (i = 0; i < POOL_SIZE; i++) begin
			value_pool[i] = $urandom;
		end
		tx_idle_en  = 1'b0;
		rx_hold_req = HOLD_CYCLES;
		while (!rx_holding) @(negedge clk);
		push_command(mk_cmd(bdq_pkg::OPC_CLEAR, 32'sd0));
		for (i = 0; i < 20; i++) begin
			push_command(mk_cmd(bdq_pkg::OPC_APPEND, pick_value()));
		end
		for (i = 0; i < 6; i++) begin
			push_command(mk_cmd(bdq_pkg::OPC_SEARCH, pick_value()));
		end
		push_command(mk_cmd(bdq_pkg::OPC_POP_FRONT, 32'sd0));
		wait_all_results();
	endtask

	// Random traffic in segments, each with its own operation mix and idling.
	task automatic test_random();
		int seg;
		int i;
		int mode;
		op_mix_t mix;
		for (i = 0; i < POOL_SIZE; i++) begin
			value_pool[i] = $urandom;
		end
		for (seg = 0; seg < 10; seg++) begin
			mode       = $urandom_range(0, 3);
			tx_idle_en = mode[0];
			rx_idle_en = mode[1];
			mix        = op_mix_t'($urandom_range(0, 2));
			for (i = 0; i < 100; i++) begin
				push_command(pick_command(mix));
			end
		end
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		wait_all_results();
	endtask

	// Reset, the tests in turn, then the verdict.
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_back_pressure();
		test_random();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
